// File: design/b64d_pkg.sv
package b64d_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);

  localparam logic [7:0] PadChar = 8'h3D;

  typedef logic [5:0] sextet_t;
  typedef logic [1:0] byte_count_t;

  typedef struct packed {
    logic [2:0][7:0] data;
    byte_count_t count;
    logic last;
  } group_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t v;
    v = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B || c == 8'h2D || c == 8'h2E) begin
      v = 6'd62;
    end else if (c == 8'h2C || c == 8'h2F || c == 8'h5F) begin
      v = 6'd63;
    end
    return v;
  endfunction

endpackage

// File: design/b64d_char_if.sv
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source(output valid, char_code, last_char, input ready);
  modport sink(input valid, char_code, last_char, output ready);
endinterface

// File: design/b64d_byte_if.sv
interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, data_byte, last_byte, input ready);
  modport sink(input valid, data_byte, last_byte, output ready);
endinterface

// File: design/b64d_front.sv
module b64d_front (
  input  logic               clk,
  input  logic               rst,
  b64d_char_if.sink          enc,
  output logic               push_valid,
  input  logic               push_ready,
  output b64d_pkg::group_t   push_rec
);

  logic [1:0]          group_position;
  logic [17:0]         sextet_accumulator;
  logic                third_was_pad;
  logic [1:0]          group_position_next;
  logic [17:0]         sextet_accumulator_next;
  logic                third_was_pad_next;
  b64d_pkg::sextet_t   v;
  logic                is_pad;
  logic [23:0]         n;
  logic                take;
  logic                emit;

  assign enc.ready = push_ready;
  assign take = enc.valid && push_ready;
  assign v = b64d_pkg::sextet_of(enc.char_code);
  assign is_pad = (enc.char_code == b64d_pkg::PadChar);
  assign n = {sextet_accumulator, v};
  assign push_valid = take && emit;

  // group decode
  always_comb begin
    emit = 1'b0;
    push_rec.data = '0;
    push_rec.count = 2'd1;
    push_rec.last = enc.last_char;
    group_position_next = 2'd0;
    sextet_accumulator_next = '0;
    third_was_pad_next = 1'b0;
    if (!enc.last_char) begin
      if (group_position != 2'd3) begin
        group_position_next = group_position + 2'd1;
        sextet_accumulator_next = n[17:0];
        third_was_pad_next = (group_position == 2'd2) ? is_pad : third_was_pad;
      end else begin
        emit = 1'b1;
        push_rec.data = {n[7:0], n[15:8], n[23:16]};
        push_rec.count = 2'd3;
      end
    end else begin
      emit = 1'b1;
      unique case (group_position)
        2'd0: begin
          push_rec.data[0] = {v, 2'b00};
        end
        2'd1: begin
          push_rec.data[0] = n[11:4];
        end
        2'd2: begin
          if (is_pad) begin
            push_rec.data[0] = sextet_accumulator[11:4];
          end else begin
            push_rec.data[0] = n[17:10];
            push_rec.data[1] = n[9:2];
            push_rec.count = 2'd2;
          end
        end
        default: begin
          push_rec.data = {n[7:0], n[15:8], n[23:16]};
          if (!is_pad) begin
            push_rec.count = 2'd3;
          end else if (third_was_pad) begin
            push_rec.count = 2'd1;
          end else begin
            push_rec.count = 2'd2;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_position <= 2'd0;
      sextet_accumulator <= '0;
      third_was_pad <= 1'b0;
    end else if (take) begin
      group_position <= group_position_next;
      sextet_accumulator <= sextet_accumulator_next;
      third_was_pad <= third_was_pad_next;
    end
  end

endmodule

// File: design/b64d_queue.sv
module b64d_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  b64d_pkg::group_t   push_rec,
  output logic               pop_valid,
  input  logic               pop_ready,
  output b64d_pkg::group_t   pop_rec
);

  b64d_pkg::group_t                    entries [b64d_pkg::QueueDepth];
  logic [b64d_pkg::QueuePtrW-1:0]      wr_ptr;
  logic [b64d_pkg::QueuePtrW-1:0]      rd_ptr;
  logic [b64d_pkg::QueuePtrW:0]        fill;
  logic                                do_push;
  logic                                do_pop;

  assign push_ready = (fill != (b64d_pkg::QueuePtrW + 1)'(b64d_pkg::QueueDepth));
  assign pop_valid = (fill != '0);
  assign pop_rec = entries[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: design/b64d_back.sv
module b64d_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  b64d_pkg::group_t   pop_rec,
  b64d_byte_if.source        dec
);

  logic [1:0] byte_idx;
  logic       final_byte;
  logic       xfer;

  assign final_byte = (byte_idx == pop_rec.count - 2'd1);
  assign dec.valid = pop_valid;
  assign dec.last_byte = pop_rec.last && final_byte;
  assign xfer = dec.valid && dec.ready;
  assign pop_ready = dec.ready && final_byte;

  always_comb begin
    unique case (byte_idx)
      2'd0:    dec.data_byte = pop_rec.data[0];
      2'd1:    dec.data_byte = pop_rec.data[1];
      default: dec.data_byte = pop_rec.data[2];
    endcase
  end

  // byte position inside the head group
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx <= 2'd0;
    end else if (xfer) begin
      byte_idx <= final_byte ? 2'd0 : byte_idx + 2'd1;
    end
  end

endmodule

// File: design/base64_stream_decoder.sv
// a group enters the registered queue when the character that closes it is taken; its bytes follow earlier groups
// throughput: one character per cycle in while the queue has room, one byte per cycle out while dec.ready is high
// a group's bytes leave one after another from a four-group queue, as dec.ready allows
// synchronous reset empties the queue and clears the group position, sextets, pad flag and byte index
module base64_stream_decoder (
  input  logic         clk,
  input  logic         rst,
  b64d_char_if.sink    enc,
  b64d_byte_if.source  dec
);

  logic               push_valid;
  logic               push_ready;
  b64d_pkg::group_t   push_rec;
  logic               pop_valid;
  logic               pop_ready;
  b64d_pkg::group_t   pop_rec;

  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .enc        (enc),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_rec   (push_rec),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_rec    (pop_rec)
  );

  b64d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_rec   (pop_rec),
    .dec       (dec)
  );

endmodule
